// ----- rtl/bmg_pkg.sv -----
// Shared types, constants and elaboration-time helpers of the Butterworth mask generator.
// No dependencies; every other file of the block but bmg_checker imports this package.
package bmg_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_HALF_SIZE      = 3'd0;
   localparam logic [2:0] CSR_CUTOFF_SCALE   = 3'd1;
   localparam logic [2:0] CSR_ORDER_EXPONENT = 3'd2;
   localparam logic [2:0] CSR_GAIN           = 3'd3;
   localparam logic [2:0] CSR_OFFSET         = 3'd4;

   // How the high-pass term of a bin is chosen
   localparam logic [1:0] SEL_NORMAL = 2'd0;  // computed from distance
   localparam logic [1:0] SEL_FULL   = 2'd1;  // DC bin or flat gain
   localparam logic [1:0] SEL_ZERO   = 2'd2;  // zero distance at a folded corner

   // High-pass term of one in Q1.14
   localparam logic [14:0] H_ONE  = 15'd16384;
   localparam logic [14:0] H_HALF = 15'd8192;

   typedef struct packed {
      logic       oog;
      logic [1:0] sel;
   } bmg_side_type;

   // Integer square root, one result bit per iteration
   function automatic longint unsigned isqrt64(longint unsigned v);
      longint unsigned res;
      longint unsigned rem;
      longint unsigned bit_v;
      int              n;
      res   = 0;
      rem   = v;
      bit_v = 64'h4000_0000_0000_0000;
      for (n = 0; n < 32; n++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-i) in Q0.30, from repeated square roots of one half
   function automatic logic [30:0] exp2_factor(int i);
      longint unsigned r;
      int              j;
      r = 64'd1 << 29;
      for (j = 1; j <= i; j++) begin
         r = isqrt64(r << 30);
      end
      return r[30:0];
   endfunction

endpackage

// ----- rtl/bmg_front.sv -----
// Input stage: grid check, corner folding and squared distance of one bin.
// Depends on bmg_pkg.
module bmg_front #(
   parameter int MAX_HALF_SIZE = 512
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [9:0]            column,
   input  logic [9:0]            row,
   input  logic [9:0]            half_size,
   input  logic [23:0]           cutoff_scale,
   output logic [20:0]           dist2,
   output bmg_pkg::bmg_side_type side
);
   import bmg_pkg::*;

   logic [9:0]   hs;
   logic [10:0]  twice_hs;
   logic         oog;
   logic [9:0]   dx;
   logic [9:0]   dy;
   logic [20:0]  dist2_in;
   bmg_side_type side_in;
   logic [20:0]  dist2_ff;
   bmg_side_type side_ff;

   // Clamp the grid size and check the bin against it
   assign hs       = (32'(half_size) > MAX_HALF_SIZE) ? 10'(MAX_HALF_SIZE) : half_size;
   assign twice_hs = {hs, 1'b0};
   assign oog      = ({1'b0, column} >= twice_hs) || ({1'b0, row} >= twice_hs);

   // Fold each axis toward the nearest corner
   assign dx = (column < hs) ? column : 10'(twice_hs - 11'd1 - {1'b0, column});
   assign dy = (row < hs) ? row : 10'(twice_hs - 11'd1 - {1'b0, row});

   assign dist2_in = 21'(20'(dx) * 20'(dx)) + 21'(20'(dy) * 20'(dy));

   // Pick the special cases now, they travel beside the data
   always_comb begin
      side_in.oog = oog;
      if (((column == '0) && (row == '0)) || (cutoff_scale == '0)) begin
         side_in.sel = SEL_FULL;
      end else if ((dx == '0) && (dy == '0)) begin
         side_in.sel = SEL_ZERO;
      end else begin
         side_in.sel = SEL_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist2_ff <= dist2_in;
         side_ff  <= side_in;
      end
   end

   assign dist2 = dist2_ff;
   assign side  = side_ff;

endmodule

// ----- rtl/bmg_log2.sv -----
// Pipelined log2 in Q.16: normalize, then one mantissa squaring per stage.
// Depends on bmg_pkg.
module bmg_log2 (
   input  logic        clock,
   input  logic        en,
   input  logic [23:0] x,
   output logic [20:0] lg
);
   import bmg_pkg::*;

   localparam int STEPS = 16;

   logic [4:0]  p_in;
   logic [30:0] m_in;
   logic [4:0]  p_ff [0:STEPS];
   logic [30:0] m_ff [0:STEPS];
   logic [15:0] f_ff [0:STEPS];

   // Find the leading one and normalize the mantissa to Q1.30
   always_comb begin
      p_in = '0;
      for (int i = 0; i < 24; i++) begin
         if (x[i]) begin
            p_in = 5'(i);
         end
      end
   end
   assign m_in = 31'(x) << (5'd30 - p_in);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= p_in;
         m_ff[0] <= m_in;
         f_ff[0] <= '0;
      end
   end

   // Square the mantissa; a carry past two gives a fraction bit of one
   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic [61:0] sq;
      logic [31:0] sh;
      assign sq = 62'(m_ff[g]) * 62'(m_ff[g]);
      assign sh = sq[61:30];
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[g+1] <= p_ff[g];
            m_ff[g+1] <= sh[31] ? sh[31:1] : sh[30:0];
            f_ff[g+1] <= {f_ff[g][14:0], sh[31]};
         end
      end
   end

   assign lg = {p_ff[STEPS], f_ff[STEPS]};

endmodule

// ----- rtl/bmg_exp2.sv -----
// Log ratio, scaling by the order and pipelined 2^-t in Q1.30.
// Depends on bmg_pkg (exp2_factor constants).
module bmg_exp2 (
   input  logic        clock,
   input  logic        en,
   input  logic [20:0] lg_dist,
   input  logic [20:0] lg_cut,
   input  logic [11:0] order_exponent,
   output logic [30:0] u,
   output logic        negt
);
   import bmg_pkg::*;

   localparam int STEPS = 16;

   logic [21:0] pos;
   logic [21:0] neg;
   logic        neg_a_ff;
   logic [21:0] mag_a_ff;
   logic [33:0] prod_b;
   logic [30:0] acc_ff [0:STEPS];
   logic [9:0]  k_ff   [0:STEPS];
   logic [15:0] fr_ff  [0:STEPS];
   logic        ng_ff  [0:STEPS];
   logic [30:0] u_ff;
   logic        negt_ff;

   // Magnitude and sign of log2(dist2 * 256 / cutoff)
   assign pos = 22'(lg_dist) + 22'(8 << 16);
   assign neg = 22'(lg_cut);

   always_ff @(posedge clock) begin
      if (en) begin
         neg_a_ff <= neg > pos;
         mag_a_ff <= (neg > pos) ? neg - pos : pos - neg;
      end
   end

   // Scale by the order exponent, split integer and fraction
   assign prod_b = 34'(order_exponent) * 34'(mag_a_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff[0] <= 31'd1 << 30;
         k_ff[0]   <= prod_b[33:24];
         fr_ff[0]  <= prod_b[23:8];
         ng_ff[0]  <= neg_a_ff;
      end
   end

   // One fraction bit per stage, most significant first
   for (genvar g = 1; g <= STEPS; g++) begin : g_step
      localparam logic [30:0] R = exp2_factor(g);
      logic [61:0] prod;
      assign prod = 62'(acc_ff[g-1]) * 62'(R);
      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[g] <= fr_ff[g-1][STEPS-g] ? prod[60:30] : acc_ff[g-1];
            k_ff[g]   <= k_ff[g-1];
            fr_ff[g]  <= fr_ff[g-1];
            ng_ff[g]  <= ng_ff[g-1];
         end
      end
   end

   // Apply the integer part as a right shift
   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= (k_ff[STEPS] > 10'd40) ? '0 : acc_ff[STEPS] >> k_ff[STEPS];
         negt_ff <= ng_ff[STEPS];
      end
   end

   assign u    = u_ff;
   assign negt = negt_ff;

endmodule

// ----- rtl/bmg_div.sv -----
// Rounded quotient of the high-pass term, restoring division one bit per stage.
// Depends on bmg_pkg.
module bmg_div (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] u,
   input  logic        negt,
   output logic [14:0] h
);
   import bmg_pkg::*;

   localparam int QW = 15;
   localparam logic [46:0] NUM_ONE = 47'd1 << 44;

   logic [31:0] den;
   logic [46:0] half_den;
   logic [46:0] rem_ff [0:QW];
   logic [31:0] den_ff [0:QW];
   logic [14:0] q_ff   [0:QW];

   // Build denominator and rounded numerator
   assign den      = 32'(u) + (32'd1 << 30);
   assign half_den = 47'(den >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= (negt ? (47'(u) << 14) : NUM_ONE) + half_den;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
      end
   end

   // Settle one quotient bit per stage
   for (genvar g = 0; g < QW; g++) begin : g_step
      logic [46:0] dsh;
      logic        take;
      assign dsh  = 47'(den_ff[g]) << (QW - 1 - g);
      assign take = rem_ff[g] >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g+1] <= take ? rem_ff[g] - dsh : rem_ff[g];
            den_ff[g+1] <= den_ff[g];
            q_ff[g+1]   <= q_ff[g] | (take ? (15'd1 << (QW - 1 - g)) : 15'd0);
         end
      end
   end

   assign h = q_ff[QW];

endmodule

// ----- rtl/bmg_scale.sv -----
// Output stages: special-case select, gain multiply, rounding, offset, saturation.
// Depends on bmg_pkg.
module bmg_scale (
   input  logic                  clock,
   input  logic                  en,
   input  logic [14:0]           h,
   input  bmg_pkg::bmg_side_type side,
   input  logic [11:0]           order_exponent,
   input  logic signed [15:0]    gain,
   input  logic signed [15:0]    offset,
   output logic signed [16:0]    coefficient,
   output logic                  out_of_grid
);
   import bmg_pkg::*;

   logic [14:0]        h_eff;
   logic signed [31:0] h_s;
   logic signed [31:0] g_s;
   logic signed [31:0] prod_ff;
   logic               oog_ff;
   logic signed [31:0] rnd;
   logic signed [31:0] tot;
   logic signed [16:0] coef_in;
   logic signed [16:0] coef_ff;
   logic               oog_out_ff;

   // Replace the computed term for the special bins
   always_comb begin
      case (side.sel)
         SEL_FULL: h_eff = H_ONE;
         SEL_ZERO: h_eff = (order_exponent == '0) ? H_HALF : 15'd0;
         default:  h_eff = h;
      endcase
   end

   assign h_s = $signed({17'd0, h_eff});
   assign g_s = 32'(gain);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= h_s * g_s;
         oog_ff  <= side.oog;
      end
   end

   // Round half up, add offset, clamp; out-of-grid bins give zero
   assign rnd = (prod_ff + 32'sd8192) >>> 14;
   assign tot = rnd + 32'(offset);

   always_comb begin
      if (oog_ff) begin
         coef_in = '0;
      end else if (tot > 32'sd65535) begin
         coef_in = 17'sd65535;
      end else if (tot < -32'sd65536) begin
         coef_in = -17'sd65536;
      end else begin
         coef_in = tot[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coef_ff    <= coef_in;
         oog_out_ff <= oog_ff;
      end
   end

   assign coefficient = coef_ff;
   assign out_of_grid = oog_out_ff;

endmodule

// ----- rtl/butterworth_mask_generator.sv -----
// Butterworth high-pass mask generator: one real coefficient per FFT bin request.
// Depends on bmg_pkg, bmg_front, bmg_log2, bmg_exp2, bmg_div and bmg_scale.
//
// Usage:
//   req_* carries one bin request: column in tdata[9:0], row in tdata[19:10].
//   rsp_* returns the coefficient (signed Q3.14) in tdata[16:0] and the
//   out-of-grid flag in tuser. Requests leave in the order they came in.
//   csr_* writes one register per cycle (index, data); csr_ready is always
//   high. Write registers only while no request is in flight.
// Timing:
//   Requests pass the front stage, two log2 lanes, the exponent unit, the
//   divider and the output stages in that order. The divider settles one
//   quotient bit per stage and the log2 lane one fraction bit per stage,
//   which sets the depth. Throughput is one request per cycle unless stalled.
// Reset:
//   Synchronous reset empties the pipeline and loads the register defaults.
// Back-pressure:
//   While a response waits on rsp_tready the whole pipeline holds and
//   req_tready drops; nothing is lost or repeated.
module butterworth_mask_generator #(
   parameter int MAX_HALF_SIZE = 512
) (
   input  logic        clock,
   input  logic        reset,
   // request: [9:0] column, [19:10] row, [23:20] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // response: [16:0] coefficient, [23:17] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // response: [0] out_of_grid
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import bmg_pkg::*;

   localparam int LAT    = 55;
   localparam int SB_LEN = 52;

   logic               adv;
   logic [9:0]         half_size_ff;
   logic [23:0]        cutoff_scale_ff;
   logic [11:0]        order_exponent_ff;
   logic signed [15:0] gain_ff;
   logic signed [15:0] offset_ff;
   logic               vld_ff [0:LAT-1];
   bmg_side_type       sb_ff  [0:SB_LEN-1];
   logic [20:0]        dist2;
   bmg_side_type       side;
   logic [20:0]        lg_dist;
   logic [20:0]        lg_cut;
   logic [30:0]        u;
   logic               negt;
   logic [14:0]        h;
   logic signed [16:0] coefficient;
   logic               out_of_grid;

   // Whole pipeline moves when the output register is free or taken
   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_size_ff      <= 10'd256;
         cutoff_scale_ff   <= 24'd2560;
         order_exponent_ff <= 12'd256;
         gain_ff           <= 16'sd16384;
         offset_ff         <= 16'sd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HALF_SIZE:      half_size_ff      <= csr_data[9:0];
            CSR_CUTOFF_SCALE:   cutoff_scale_ff   <= csr_data;
            CSR_ORDER_EXPONENT: order_exponent_ff <= csr_data[11:0];
            CSR_GAIN:           gain_ff           <= csr_data[15:0];
            CSR_OFFSET:         offset_ff         <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Delay the special-case flags to the divider output
   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff[0] <= side;
         for (int i = 1; i < SB_LEN; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   bmg_front #(
      .MAX_HALF_SIZE (MAX_HALF_SIZE)
   ) u_front (
      .clock        (clock),
      .en           (adv),
      .column       (req_tdata[9:0]),
      .row          (req_tdata[19:10]),
      .half_size    (half_size_ff),
      .cutoff_scale (cutoff_scale_ff),
      .dist2        (dist2),
      .side         (side)
   );

   bmg_log2 u_log_dist (
      .clock (clock),
      .en    (adv),
      .x     (24'(dist2)),
      .lg    (lg_dist)
   );

   bmg_log2 u_log_cut (
      .clock (clock),
      .en    (adv),
      .x     (cutoff_scale_ff),
      .lg    (lg_cut)
   );

   bmg_exp2 u_exp2 (
      .clock          (clock),
      .en             (adv),
      .lg_dist        (lg_dist),
      .lg_cut         (lg_cut),
      .order_exponent (order_exponent_ff),
      .u              (u),
      .negt           (negt)
   );

   bmg_div u_div (
      .clock (clock),
      .en    (adv),
      .u     (u),
      .negt  (negt),
      .h     (h)
   );

   bmg_scale u_scale (
      .clock          (clock),
      .en             (adv),
      .h              (h),
      .side           (sb_ff[SB_LEN-1]),
      .order_exponent (order_exponent_ff),
      .gain           (gain_ff),
      .offset         (offset_ff),
      .coefficient    (coefficient),
      .out_of_grid    (out_of_grid)
   );

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {7'd0, coefficient};
   assign rsp_tuser  = out_of_grid;

endmodule

// ----- rtl/bmg_checker.sv -----
// Port-level checks of the Butterworth mask generator, bound to the top level.
// Depends on butterworth_mask_generator.
module bmg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Requests are taken exactly when the output can move
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow output stall");

   // Out-of-grid bins give a zero coefficient
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 24'd0))
      else $error("out-of-grid response with nonzero coefficient");

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind butterworth_mask_generator bmg_checker u_bmg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
